// File: sv/vdk7_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// vdk7_pkg
// Shared types, constants and helpers for the K=7 rate 1/2 soft-decision
// Viterbi decoder (generators 0x6D / 0x4F, 64 states).
// ============================================================================
package vdk7_pkg;

	// opcodes of an input item
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	// code and trellis constants
	localparam logic [7:0] GEN_A   = 8'h6D;
	localparam logic [7:0] GEN_B   = 8'h4F;
	localparam int         NSTATES = 64;
	localparam int         HALF_ST = NSTATES / 2;

	// -999999 as a 32-bit two's complement word
	localparam logic [31:0] POISON = 32'hFFF0_BDC1;

	// defaults of the top level parameters
	localparam int METRIC_WIDTH_DEF = 16;

	// frame length limit
	localparam int          CNT_W      = 12;
	localparam int          MAX_PAIRS  = 4096;
	localparam logic [CNT_W-1:0] PAIR_LIMIT =
		(MAX_PAIRS - 1 > (1 << CNT_W) - 1) ? {CNT_W{1'b1}} : CNT_W'(MAX_PAIRS - 1);

	// schedule of periodic output and tail
	localparam logic [CNT_W-1:0] SEARCH_START = CNT_W'(32);
	localparam logic [2:0]       SEARCH_PHASE = 3'd5;
	localparam int               TAIL_LEN     = 7;

	// memory geometry
	localparam int TBL_DEPTH = 512;
	localparam int PM_DEPTH  = 2 * NSTATES;

	// input item
	typedef struct packed {
		logic               opcode;
		logic               table_select;
		logic [7:0]         table_index;
		logic signed [15:0] table_value;
		logic [7:0]         soft_first;
		logic [7:0]         soft_second;
	} in_item_t;

	// result item
	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_end;
	} out_item_t;

	// one entry of the path memory: metric and survivor bits
	typedef struct packed {
		logic [31:0] metric;
		logic [31:0] path;
	} pm_entry_t;

	// encoder output pair for the even state of butterfly idx
	function automatic logic [1:0] branch_sym(input logic [4:0] idx);
		logic [7:0] st;
		st = {2'b00, idx, 1'b0};
		return {^(st & GEN_A), ^(st & GEN_B)};
	endfunction

endpackage

// File: sv/vdk7_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// vdk7_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ============================================================================
module vdk7_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: sv/viterbi_decoder_k7_rate_half_top.sv
`timescale 1ns / 1ps
// ============================================================================
// viterbi_decoder_k7_rate_half_top
// Soft-decision Viterbi decoder, K=7 rate 1/2, 64 states, 32-bit survivors.
// ============================================================================
// A load item (opcode 0) writes one entry of the 2x256 branch metric table.
// A decode item (opcode 1) takes one soft symbol pair: four table reads,
// then 32 add-compare-select butterflies that stream through the path
// memory (one 64-bit metric/survivor entry read and one written per cycle).
// On every eighth pair past pair 32 a best-state search reads all 64 new
// entries, one per cycle, adding one output byte (bits 31..24 of the best
// path). The last pair of a frame flushes state 0's path as four bytes, the
// last flagged frame_end, and rearms the decoder. The frame length is
// pair_count, which the user must write through cfg_we/cfg_data only while
// idle; the block does not enforce this. Result bytes leave through a
// registered output that holds while the output side stalls. Table entries
// must be loaded before they are used; path state starts out cleared by
// reset, with no clearing pass.
// ============================================================================
module viterbi_decoder_k7_rate_half_top #(
	parameter int METRIC_WIDTH = vdk7_pkg::METRIC_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  vdk7_pkg::in_item_t          in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output vdk7_pkg::out_item_t         out_data,
	input  logic                        cfg_we,
	input  logic [vdk7_pkg::CNT_W-1:0]  cfg_data
);

	localparam int TBL_AW = $clog2(vdk7_pkg::TBL_DEPTH);
	localparam int PM_AW  = $clog2(vdk7_pkg::PM_DEPTH);
	localparam int CW     = vdk7_pkg::CNT_W;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_MREAD = 6'b000010,
		ST_MSUM  = 6'b000100,
		ST_ACS   = 6'b001000,
		ST_SRCH  = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	// control state
	state_t                       state_q;
	logic [6:0]                   step_q;
	logic                         bank_q;
	logic [CW-1:0]                cnt_q;
	logic [CW-1:0]                pair_count_q;
	logic [vdk7_pkg::PM_DEPTH-1:0] ent_vld_q;
	logic                         rd_tbl_s1;
	logic                         rd_acs_s1;
	logic                         rd_srch_s1;
	logic                         bf_vld_s2;
	logic                         odd_pend_q;
	logic [2:0]                   emit_q;
	logic                         out_valid_q;

	// payload registers
	logic [7:0]                   soft_first_q;
	logic [7:0]                   soft_second_q;
	logic [31:0]                  tm_q [4];
	logic [31:0]                  mets_q [4];
	logic                         tail_q;
	logic                         per_q;
	logic                         flush_q;
	logic [1:0]                   rd_tk_s1;
	logic                         rd_hi_s1;
	logic [4:0]                   rd_i_s1;
	logic                         rd_st0_s1;
	logic                         rd_ev_s1;
	logic                         rd_z_s1;
	logic [31:0]                  lo_metric_q;
	logic [31:0]                  lo_path_q;
	logic [4:0]                   bf_i_s2;
	vdk7_pkg::pm_entry_t          even_s2;
	vdk7_pkg::pm_entry_t          odd_s2;
	logic [31:0]                  surv0_q;
	logic [31:0]                  best_metric_q;
	logic [31:0]                  best_path_q;
	vdk7_pkg::out_item_t          out_data_q;

	// combinational
	logic                         in_acc;
	logic                         oslot;
	logic [CW-1:0]                limit;
	logic                         tbl_we;
	logic [TBL_AW-1:0]            tbl_waddr;
	logic [TBL_AW-1:0]            tbl_raddr;
	logic [METRIC_WIDTH-1:0]      tbl_wdata;
	logic [METRIC_WIDTH-1:0]      tbl_rdata;
	logic signed [31:0]           tv_ext;
	logic [31:0]                  tbl_ext;
	logic                         pm_we;
	logic [PM_AW-1:0]             pm_waddr;
	logic [PM_AW-1:0]             pm_raddr;
	vdk7_pkg::pm_entry_t          pm_wdata;
	vdk7_pkg::pm_entry_t          pm_rdata;
	logic [5:0]                   st_sel;
	logic [31:0]                  rd_metric;
	logic [31:0]                  rd_path;
	logic [1:0]                   sym;
	logic [31:0]                  ma;
	logic [31:0]                  mb;
	logic [31:0]                  e0;
	logic [31:0]                  e1;
	logic [31:0]                  o0;
	logic [31:0]                  o1;
	logic [31:0]                  plo;
	logic [31:0]                  phi;
	vdk7_pkg::pm_entry_t          even_c;
	vdk7_pkg::pm_entry_t          odd_c;
	logic [2:0]                   nres;
	logic [2:0]                   r_ph;
	logic [31:0]                  fpath;
	logic [1:0]                   fb;
	vdk7_pkg::out_item_t          emit_item;

	// handshakes
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign oslot     = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// frame length clamp
	assign limit = (pair_count_q > vdk7_pkg::PAIR_LIMIT) ? vdk7_pkg::PAIR_LIMIT : pair_count_q;

	// branch metric table: written by load items, read four times per pair
	assign tv_ext    = 32'(signed'(in_data.table_value));
	assign tbl_we    = in_acc && (in_data.opcode == vdk7_pkg::OP_LOAD);
	assign tbl_waddr = {in_data.table_select, in_data.table_index};
	assign tbl_wdata = tv_ext[METRIC_WIDTH-1:0];
	assign tbl_raddr = {step_q[1], step_q[0] ? soft_second_q : soft_first_q};
	assign tbl_ext   = 32'(signed'(tbl_rdata));

	vdk7_ram #(
		.WIDTH (METRIC_WIDTH),
		.DEPTH (vdk7_pkg::TBL_DEPTH)
	) u_tbl_ram (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	// path memory: bank in the top address bit, state below
	assign st_sel   = (state_q == ST_ACS) ? {step_q[0], step_q[5:1]} : step_q[5:0];
	assign pm_raddr = {bank_q, st_sel};
	assign pm_we    = bf_vld_s2 || odd_pend_q;
	assign pm_waddr = {~bank_q, bf_i_s2, odd_pend_q};
	assign pm_wdata = odd_pend_q ? odd_s2 : even_s2;

	vdk7_ram #(
		.WIDTH ($bits(vdk7_pkg::pm_entry_t)),
		.DEPTH (vdk7_pkg::PM_DEPTH)
	) u_pm_ram (
		.clk   (clk),
		.we    (pm_we),
		.waddr (pm_waddr),
		.wdata (pm_wdata),
		.raddr (pm_raddr),
		.rdata (pm_rdata)
	);

	// unwritten entries read as the frame start values
	assign rd_metric = rd_ev_s1 ? pm_rdata.metric : (rd_z_s1 ? 32'd0 : vdk7_pkg::POISON);
	assign rd_path   = rd_ev_s1 ? pm_rdata.path : 32'd0;

	// add-compare-select butterfly, upper predecessor wins a tie
	always_comb begin
		sym = vdk7_pkg::branch_sym(rd_i_s1);
		ma  = mets_q[sym];
		mb  = mets_q[~sym];
		e0  = lo_metric_q + ma;
		e1  = rd_metric + mb;
		o0  = lo_metric_q + mb;
		o1  = rd_metric + ma;
		plo = {lo_path_q[30:0], 1'b0};
		phi = {rd_path[30:0], 1'b1};
		if ($signed(e0) > $signed(e1)) begin
			even_c = '{metric: e0, path: plo};
		end else begin
			even_c = '{metric: e1, path: phi};
		end
		if ($signed(o0) > $signed(o1)) begin
			odd_c = '{metric: o0, path: plo};
		end else begin
			odd_c = '{metric: o1, path: phi};
		end
		if (tail_q) begin
			odd_c.metric = vdk7_pkg::POISON;
		end
	end

	// flush alignment of state 0's path by frame phase
	assign r_ph = cnt_q[2:0] + 3'd1;
	always_comb begin
		unique case (r_ph)
			3'd7:    fpath = surv0_q >> 1;
			3'd6:    fpath = surv0_q;
			default: fpath = surv0_q << (3'd6 - r_ph);
		endcase
	end

	// result sequence: periodic byte first, then four flush bytes
	assign nres = {flush_q, 2'b00} + {2'b00, per_q};
	assign fb   = 2'(emit_q - {2'b00, per_q});
	always_comb begin
		emit_item.frame_end = 1'b0;
		if (per_q && (emit_q == 3'd0)) begin
			emit_item.out_byte = best_path_q[31:24];
		end else begin
			unique case (fb)
				2'd0: emit_item.out_byte = fpath[31:24];
				2'd1: emit_item.out_byte = fpath[23:16];
				2'd2: emit_item.out_byte = fpath[15:8];
				2'd3: emit_item.out_byte = fpath[7:0];
			endcase
			emit_item.frame_end = (fb == 2'd3);
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_q       <= '0;
			bank_q       <= 1'b0;
			cnt_q        <= '0;
			pair_count_q <= CW'(1);
			ent_vld_q    <= '0;
			rd_tbl_s1    <= 1'b0;
			rd_acs_s1    <= 1'b0;
			rd_srch_s1   <= 1'b0;
			bf_vld_s2    <= 1'b0;
			odd_pend_q   <= 1'b0;
			emit_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				pair_count_q <= cfg_data;
			end

			// read tracking, registered in step with the memories' read data
			rd_tbl_s1  <= (state_q == ST_MREAD) && !step_q[2];
			rd_acs_s1  <= (state_q == ST_ACS) && !step_q[6];
			rd_srch_s1 <= (state_q == ST_SRCH) && !step_q[6];

			// butterfly results, then the odd write in the cycle after
			bf_vld_s2  <= rd_acs_s1 && rd_hi_s1;
			odd_pend_q <= bf_vld_s2;

			// output register: load a new item or drop the taken one
			if ((state_q == ST_EMIT) && (emit_q < nres) && oslot) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (pm_we) begin
				ent_vld_q[pm_waddr] <= 1'b1;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && (in_data.opcode == vdk7_pkg::OP_DECODE)) begin
						state_q <= ST_MREAD;
						step_q  <= '0;
					end
				end
				ST_MREAD: begin
					step_q <= step_q + 7'd1;
					if (step_q == 7'd4) begin
						state_q <= ST_MSUM;
					end
				end
				ST_MSUM: begin
					state_q <= ST_ACS;
					step_q  <= '0;
				end
				ST_ACS: begin
					if (step_q == 7'd66) begin
						bank_q <= ~bank_q;
						step_q <= '0;
						emit_q <= '0;
						state_q <= per_q ? ST_SRCH : ST_EMIT;
					end else begin
						step_q <= step_q + 7'd1;
					end
				end
				ST_SRCH: begin
					step_q <= step_q + 7'd1;
					if (step_q == 7'd64) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_q < nres) begin
						if (oslot) begin
							emit_q <= emit_q + 3'd1;
						end
					end else begin
						// end of pair: rearm on flush, else advance
						if (flush_q) begin
							bank_q    <= 1'b0;
							cnt_q     <= '0;
							ent_vld_q <= '0;
						end else begin
							cnt_q <= cnt_q + CW'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			soft_first_q  <= in_data.soft_first;
			soft_second_q <= in_data.soft_second;
		end

		// table read tags and captured metrics
		rd_tk_s1 <= step_q[1:0];
		if (rd_tbl_s1) begin
			tm_q[rd_tk_s1] <= tbl_ext;
		end

		// per-pair branch sums and frame decisions
		if (state_q == ST_MSUM) begin
			mets_q[0] <= tm_q[0] + tm_q[1];
			mets_q[1] <= tm_q[0] + tm_q[3];
			mets_q[2] <= tm_q[2] + tm_q[1];
			mets_q[3] <= tm_q[2] + tm_q[3];
			tail_q    <= ({1'b0, cnt_q} + (CW+1)'(vdk7_pkg::TAIL_LEN)) > {1'b0, limit};
			flush_q   <= ({1'b0, cnt_q} + (CW+1)'(1)) >= {1'b0, limit};
			per_q     <= (cnt_q[2:0] == vdk7_pkg::SEARCH_PHASE) &&
			             (cnt_q > vdk7_pkg::SEARCH_START);
		end

		// path memory read tags
		rd_hi_s1  <= step_q[0];
		rd_i_s1   <= step_q[5:1];
		rd_st0_s1 <= (step_q[5:0] == 6'd0);
		rd_ev_s1  <= ent_vld_q[pm_raddr];
		rd_z_s1   <= (pm_raddr == '0);

		// lower predecessor held until the upper one arrives
		if (rd_acs_s1 && !rd_hi_s1) begin
			lo_metric_q <= rd_metric;
			lo_path_q   <= rd_path;
		end
		if (rd_acs_s1 && rd_hi_s1) begin
			even_s2 <= even_c;
			odd_s2  <= odd_c;
			bf_i_s2 <= rd_i_s1;
		end

		// state 0 survivor kept for the flush
		if (bf_vld_s2 && (bf_i_s2 == 5'd0)) begin
			surv0_q <= even_s2.path;
		end

		// best state search, lowest state wins a tie
		if (rd_srch_s1 && (rd_st0_s1 || ($signed(rd_metric) > $signed(best_metric_q)))) begin
			best_metric_q <= rd_metric;
			best_path_q   <= rd_path;
		end

		if ((state_q == ST_EMIT) && (emit_q < nres) && oslot) begin
			out_data_q <= emit_item;
		end
	end

endmodule

// File: verif/viterbi_decoder_k7_rate_half_top_test.sv
`timescale 1ns / 1ps
// ============================================================================
// viterbi_decoder_k7_rate_half_top_test
// Self-checking bench for the K=7 rate 1/2 soft-decision Viterbi decoder.
// Table loads and symbol pairs are queued by a stimulus process and sent by
// a bursty driver. Every accepted item runs through a bit-exact trellis
// predictor that queues the bytes the decoder must emit. A monitor with its
// own stall pattern checks each output byte and its frame_end flag in order.
// Frame lengths from the zero and one pair extremes up to the 4095 limit are
// set, and the length is also changed in the middle of a frame.
// ============================================================================
module viterbi_decoder_k7_rate_half_top_test;
	import vdk7_pkg::*;

	localparam int          ITEM_TARGET    = 430;
	localparam int          SETTLE_CYCLES  = 200;
	localparam int          TIMEOUT_CYCLES = 1000000;
	localparam int          MAX_REPORTS    = 10;
	localparam logic [7:0]  STRONG_ZERO    = 8'd28;
	localparam logic [7:0]  STRONG_ONE     = 8'd228;
	localparam logic [7:0]  ERASURE        = 8'd128;

	typedef struct {
		in_item_t item;
		bit       drain;
	} pending_t;

	logic                clk;
	logic                arst_n   = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	in_item_t            in_data  = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	out_item_t           out_data;
	logic                cfg_we    = 1'b0;
	logic [CNT_W-1:0]    cfg_data  = '0;

	// queues between stimulus, driver and monitor
	pending_t            pending_q[$];
	out_item_t           expected_bytes_q[$];

	// predictor state
	logic signed [15:0]  metric_tbl [TBL_DEPTH];
	logic [31:0]         path_metric [2][NSTATES];
	logic [31:0]         survivor [2][NSTATES];
	logic                bank;
	logic [CNT_W-1:0]    pair_ctr;
	logic [CNT_W-1:0]    frame_len;

	// stimulus bookkeeping
	logic [1:0]          loaded_halves [256];
	int                  usable_syms[$];
	bit                  drain_next;
	int                  n_queued;

	// statistics
	int                  n_loads;
	int                  n_pairs;
	int                  n_checked;
	int                  n_frames;
	int                  n_settings;
	int                  error_count;
	int                  cycle_cnt;

	// driver and receiver pacing
	int                  burst_left = 1;
	int                  gap_left   = 0;
	int                  rx_mode      = 0;
	int                  rx_mode_left = 0;
	int                  rx_stall_left = 0;

	viterbi_decoder_k7_rate_half_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// sign-extended branch metric
	function automatic logic [31:0] branch_metric(input logic half, input logic [7:0] idx);
		logic signed [15:0] v;
		v = metric_tbl[{half, idx}];
		return {{16{v[15]}}, v};
	endfunction

	// start of frame: state 0 at zero, the rest poisoned
	function automatic void clear_paths();
		for (int s = 0; s < NSTATES; s++) begin
			path_metric[0][s] = POISON;
			path_metric[1][s] = POISON;
			survivor[0][s] = '0;
			survivor[1][s] = '0;
		end
		path_metric[0][0] = '0;
		bank = 1'b0;
		pair_ctr = '0;
	endfunction

	// trellis update for one accepted item, queues the bytes it causes
	task automatic predict_item(input in_item_t it);
		logic [31:0] bm [4];
		logic [31:0] lo, hi, plo, phi, m0, m1, best, path;
		logic [7:0]  st;
		logic [1:0]  sym;
		int          i, cur, nxt, limit, cnt, bs, r;
		out_item_t   res;
		if (it.opcode == OP_LOAD) begin
			metric_tbl[{it.table_select, it.table_index}] = it.table_value;
			n_loads++;
		end else begin
			n_pairs++;
			bm[0] = branch_metric(1'b0, it.soft_first) + branch_metric(1'b0, it.soft_second);
			bm[1] = branch_metric(1'b0, it.soft_first) + branch_metric(1'b1, it.soft_second);
			bm[2] = branch_metric(1'b1, it.soft_first) + branch_metric(1'b0, it.soft_second);
			bm[3] = branch_metric(1'b1, it.soft_first) + branch_metric(1'b1, it.soft_second);
			cur = int'(bank);
			nxt = cur ^ 1;
			// 32 butterflies, upper predecessor wins a tie
			for (i = 0; i < HALF_ST; i++) begin
				st  = 8'(i << 1);
				sym = {^(st & GEN_A), ^(st & GEN_B)};
				lo  = path_metric[cur][i];
				hi  = path_metric[cur][i + HALF_ST];
				plo = survivor[cur][i] << 1;
				phi = (survivor[cur][i + HALF_ST] << 1) | 32'd1;
				m0 = lo + bm[sym];
				m1 = hi + bm[2'b11 ^ sym];
				if ($signed(m0) > $signed(m1)) begin
					path_metric[nxt][2 * i] = m0;
					survivor[nxt][2 * i] = plo;
				end else begin
					path_metric[nxt][2 * i] = m1;
					survivor[nxt][2 * i] = phi;
				end
				m0 = lo + bm[2'b11 ^ sym];
				m1 = hi + bm[sym];
				if ($signed(m0) > $signed(m1)) begin
					path_metric[nxt][2 * i + 1] = m0;
					survivor[nxt][2 * i + 1] = plo;
				end else begin
					path_metric[nxt][2 * i + 1] = m1;
					survivor[nxt][2 * i + 1] = phi;
				end
			end
			bank = nxt[0];
			cur = nxt;
			limit = int'(frame_len);
			if (limit > MAX_PAIRS - 1) begin
				limit = MAX_PAIRS - 1;
			end
			cnt = int'(pair_ctr);
			// tail: odd states are unreachable
			if (cnt > limit - TAIL_LEN) begin
				for (i = 1; i < NSTATES; i += 2) begin
					path_metric[cur][i] = POISON;
				end
			end
			// periodic best-state byte, lowest state wins a tie
			if ((cnt % 8) == int'(SEARCH_PHASE) && cnt > int'(SEARCH_START)) begin
				best = path_metric[cur][0];
				bs = 0;
				for (i = 1; i < NSTATES; i++) begin
					if ($signed(path_metric[cur][i]) > $signed(best)) begin
						best = path_metric[cur][i];
						bs = i;
					end
				end
				path = survivor[cur][bs];
				res.out_byte = path[31:24];
				res.frame_end = 1'b0;
				expected_bytes_q.push_back(res);
			end
			// end of frame: flush state 0, aligned to the byte grid
			if (cnt >= limit - 1) begin
				r = (cnt + 1) % 8;
				path = survivor[cur][0];
				if (r == 7) begin
					path = path >> 1;
				end else if (r != 6) begin
					path = path << (6 - r);
				end
				for (i = 3; i >= 0; i--) begin
					res.out_byte = path[8 * i +: 8];
					res.frame_end = (i == 0);
					expected_bytes_q.push_back(res);
				end
				clear_paths();
			end else begin
				pair_ctr = CNT_W'(cnt + 1);
			end
		end
	endtask

	// driver: bursts with random gaps, holds for drain-marked items
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				predict_item(in_data);
			end
			if (in_valid && !in_ready) begin
				// item still waiting, keep it
			end else if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_q.size() > 0 &&
					!(pending_q[0].drain && expected_bytes_q.size() > 0)) begin
				in_valid <= 1'b1;
				in_data <= pending_q[0].item;
				pending_q.pop_front();
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 12);
					if ($urandom_range(0, 3) == 0) begin
						gap_left = $urandom_range(0, 150);
					end else if ($urandom_range(0, 1) == 0) begin
						gap_left = 0;
					end else begin
						gap_left = $urandom_range(1, 4);
					end
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: checks each output item, stalls on its own pattern
	always @(posedge clk) begin
		logic     rdy;
		out_item_t exp_item;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_bytes_q.size() == 0) begin
					error_count++;
					if (error_count <= MAX_REPORTS) begin
						$display("unexpected output byte %02h end %0b", out_data.out_byte,
							out_data.frame_end);
					end
				end else begin
					exp_item = expected_bytes_q.pop_front();
					n_checked++;
					if (out_data.frame_end) begin
						n_frames++;
					end
					if (out_data.out_byte !== exp_item.out_byte ||
							out_data.frame_end !== exp_item.frame_end) begin
						error_count++;
						if (error_count <= MAX_REPORTS) begin
							$display("mismatch on byte %0d: expected %02h end %0b, got %02h end %0b",
								n_checked, exp_item.out_byte, exp_item.frame_end,
								out_data.out_byte, out_data.frame_end);
						end
					end
				end
			end
			if (rx_mode_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_mode_left = $urandom_range(50, 600);
			end else begin
				rx_mode_left--;
			end
			if (rx_mode == 0) begin
				rdy = 1'b1;
			end else if (rx_stall_left > 0) begin
				rx_stall_left--;
				rdy = 1'b0;
			end else if ($urandom_range(0, 31) == 0) begin
				rx_stall_left = $urandom_range(1, 30);
				rdy = 1'b0;
			end else begin
				case (rx_mode)
					1: begin
						rdy = ($urandom_range(0, 3) != 0);
					end
					2: begin
						rdy = ($urandom_range(0, 3) == 0);
					end
					default: begin
						rdy = ((cycle_cnt % 5) < 2);
					end
				endcase
			end
			out_ready <= rdy;
		end
	end

	// cycle counter and timeout
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	initial begin
		wait (cycle_cnt >= TIMEOUT_CYCLES);
		$display("timeout after %0d cycles, %0d bytes still expected", cycle_cnt,
			expected_bytes_q.size());
		$display("tb: failure");
		$finish;
	end

	// queue one item, taking any pending drain mark
	task automatic enqueue_item(input in_item_t it);
		pending_t p;
		p.item = it;
		p.drain = drain_next;
		drain_next = 1'b0;
		pending_q.push_back(p);
		n_queued++;
	endtask

	task automatic add_load(input logic half, input logic [7:0] idx, input logic [15:0] val);
		in_item_t it;
		it = in_item_t'($urandom());
		it.opcode = OP_LOAD;
		it.table_select = half;
		it.table_index = idx;
		it.table_value = val;
		if (loaded_halves[idx] != 2'b11) begin
			loaded_halves[idx][half] = 1'b1;
			if (loaded_halves[idx] == 2'b11) begin
				usable_syms.push_back(int'(idx));
			end
		end
		enqueue_item(it);
	endtask

	task automatic add_pair(input logic [7:0] a, input logic [7:0] b);
		in_item_t it;
		it = in_item_t'({$urandom(), $urandom()});
		it.opcode = OP_DECODE;
		it.soft_first = a;
		it.soft_second = b;
		enqueue_item(it);
	endtask

	task automatic random_load();
		logic [15:0] val;
		case ($urandom_range(0, 7))
			0: val = 16'h8000;
			1: val = 16'h7FFF;
			default: val = 16'($urandom());
		endcase
		add_load(1'($urandom()), 8'($urandom()), val);
	endtask

	// only symbols whose two table halves are loaded
	function automatic logic [7:0] pick_sym();
		return 8'(usable_syms[$urandom_range(0, usable_syms.size() - 1)]);
	endfunction

	// everything sent, answered, and the block given time to finish
	task automatic wait_idle();
		while (pending_q.size() != 0 || in_valid || expected_bytes_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// new frame length, then encoded frames with noise or random symbol pairs, loads mixed in
	task automatic run_phase(input logic [CNT_W-1:0] len, input int npairs,
			input bit well_formed);
		int         eff, pos, k;
		logic [7:0] sr;
		logic       b;
		logic [7:0] sa, sb;
		wait_idle();
		cfg_we <= 1'b1;
		cfg_data <= len;
		frame_len = len;
		@(posedge clk);
		cfg_we <= 1'b0;
		n_settings++;
		eff = (len == 0) ? 1 : int'(len);
		pos = int'(pair_ctr);
		sr = '0;
		for (k = 0; k < npairs; k++) begin
			if ($urandom_range(0, 9) == 0) begin
				random_load();
			end
			if ($urandom_range(0, 39) == 0) begin
				drain_next = 1'b1;
			end
			if (well_formed && $urandom_range(0, 19) != 0) begin
				// encoder output, zero tail bits at frame end
				b = (pos >= eff - 6) ? 1'b0 : 1'($urandom());
				sr = {1'b0, sr[5:0], b};
				sa = ^(sr & GEN_A) ? STRONG_ONE : STRONG_ZERO;
				sb = ^(sr & GEN_B) ? STRONG_ONE : STRONG_ZERO;
				if ($urandom_range(0, 15) == 0) begin
					sa = ERASURE;
				end
				if ($urandom_range(0, 15) == 0) begin
					sb = ERASURE;
				end
			end else begin
				sa = pick_sym();
				sb = pick_sym();
			end
			add_pair(sa, sb);
			pos++;
			if (pos >= eff) begin
				pos = 0;
				sr = '0;
			end
		end
	endtask

	// stimulus
	initial begin
		int np;
		logic [CNT_W-1:0] len;
		for (int i = 0; i < TBL_DEPTH; i++) begin
			metric_tbl[i] = '0;
		end
		for (int i = 0; i < 256; i++) begin
			loaded_halves[i] = 2'b00;
		end
		clear_paths();
		frame_len = CNT_W'(1);
		drain_next = 1'b0;
		n_queued = 0;
		n_loads = 0;
		n_pairs = 0;
		n_checked = 0;
		n_frames = 0;
		n_settings = 0;
		error_count = 0;
		cycle_cnt = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// table extremes, strong symbols and an all-zero erasure entry (ties)
		add_load(1'b0, STRONG_ZERO, 16'sd100);
		add_load(1'b1, STRONG_ZERO, -16'sd100);
		add_load(1'b0, STRONG_ONE, -16'sd100);
		add_load(1'b1, STRONG_ONE, 16'sd100);
		add_load(1'b0, ERASURE, 16'sd0);
		add_load(1'b1, ERASURE, 16'sd0);
		add_load(1'b0, 8'd0, 16'h7FFF);
		add_load(1'b1, 8'd0, 16'h8000);
		add_load(1'b0, 8'd255, 16'h8000);
		add_load(1'b1, 8'd255, 16'h7FFF);
		// reset frame length of one: each pair flushes
		add_pair(STRONG_ZERO, STRONG_ZERO);
		add_pair(STRONG_ONE, STRONG_ONE);
		add_pair(STRONG_ZERO, STRONG_ONE);
		add_pair(ERASURE, ERASURE);
		add_pair(8'd0, 8'd255);
		add_pair(8'd255, 8'd0);
		add_pair(8'd0, 8'd0);
		add_pair(8'd255, 8'd255);

		// fixed frame lengths around the tail and byte boundaries
		run_phase(CNT_W'(1), 6, 1'b1);
		run_phase(CNT_W'(0), 6, 1'b1);
		run_phase(CNT_W'(2), 8, 1'b1);
		run_phase(CNT_W'(7), 14, 1'b1);
		run_phase(CNT_W'(8), 16, 1'b0);
		run_phase(CNT_W'(9), 18, 1'b1);
		drain_next = 1'b1;
		run_phase(CNT_W'(40), 80, 1'b1);
		// longest frame, cut short by a new length mid-frame
		run_phase(PAIR_LIMIT, 45, 1'b1);
		run_phase(CNT_W'(41), 1, 1'b1);
		run_phase(CNT_W'(48), 50, 1'b1);
		run_phase(CNT_W'(33), 34, 1'b0);

		// random lengths until the item budget is spent
		while (n_queued < ITEM_TARGET) begin
			len = CNT_W'($urandom_range(1, 50));
			np = $urandom_range(int'(len), 2 * int'(len) + 5);
			if (np > ITEM_TARGET - n_queued + 5) begin
				np = ITEM_TARGET - n_queued + 5;
			end
			run_phase(len, np, ($urandom_range(0, 3) != 0));
		end

		wait_idle();
		$display("covered %0d table loads and %0d symbol pairs over %0d frame lengths",
			n_loads, n_pairs, n_settings);
		$display("%0d output bytes checked, %0d frames flushed, %0d errors", n_checked,
			n_frames, error_count);
		if (error_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
